@@ rtl/nfba_pkg.sv @@
// ----------------------------------------------------------------------------
// nfba_pkg
// Shared widths, codes and types of the next-fit bitmap allocator.
// ----------------------------------------------------------------------------
package nfba_pkg;

  // Field widths
  localparam int unsigned ID_W   = 16;            // cluster id
  localparam int unsigned TOT_W  = 17;            // cluster counts
  localparam int unsigned BYTE_W = 8;             // bitmap word
  localparam int unsigned NB_W   = TOT_W - 3;     // byte counts of the map

  // Limits and reset values
  localparam int unsigned ID_LIMIT         = 65536;
  localparam int unsigned MAX_CLUSTERS_DEF = 65536;
  localparam logic [TOT_W-1:0] TOTAL_RESET = 17'd65536;

  // Lowest cluster of a byte sits in its most significant bit
  localparam logic [BYTE_W-1:0] TOP_MARK = 8'h80;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_FULL     = 2'd1,
    ST_RANGE    = 2'd2,
    ST_WAS_FREE = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_CHECK,
    S_RESULT
  } state_t;

endpackage

@@ rtl/nfba_req_if.sv @@
// ----------------------------------------------------------------------------
// nfba_req_if
// Request channel: allocate or free one cluster.
// ----------------------------------------------------------------------------
interface nfba_req_if import nfba_pkg::*; ();
  logic            valid;
  logic            ready;
  op_t             op;
  logic [ID_W-1:0] free_id;

  modport source (output valid, output op, output free_id, input ready);
  modport sink   (input valid, input op, input free_id, output ready);
endinterface

@@ rtl/nfba_rsp_if.sv @@
// ----------------------------------------------------------------------------
// nfba_rsp_if
// Response channel: granted id, status and free cluster count.
// ----------------------------------------------------------------------------
interface nfba_rsp_if import nfba_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ID_W-1:0]  granted_id;
  status_t          status;
  logic [TOT_W-1:0] free_count;

  modport source (output valid, output granted_id, output status, output free_count,
                  input ready);
  modport sink   (input valid, input granted_id, input status, input free_count,
                  output ready);
endinterface

@@ rtl/nfba_ram.sv @@
// ----------------------------------------------------------------------------
// nfba_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module nfba_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/next_fit_bitmap_allocator.sv @@
// ----------------------------------------------------------------------------
// next_fit_bitmap_allocator
// Next-fit cluster allocator over a used/free bitmap held in one RAM.
// ----------------------------------------------------------------------------
// The block holds one bit per cluster (set = used, lowest cluster in the MSB
// of each byte) in a byte-wide RAM, plus a next-fit cursor and a used count.
// After reset it runs a clearing pass of one byte per cycle over
// (MAX_CLUSTERS, capped at 65536, + 7) / 8 map bytes (8192 at the default)
// before the first request is taken; total_clusters may be written during
// that pass. An allocation reads bitmap bytes from the byte that holds the
// cursor up to the first byte with a free cluster: the map RAM delivers one
// byte per cycle. A full map reads ceil(total / 8) bytes. A free reads and
// checks its byte; an out-of-range free or an empty-volume allocation skips
// the map. One request is worked at a time; a finished response waits in the
// output register while the next is taken. The user writes total_clusters
// through cfg_we/cfg_wdata while idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module next_fit_bitmap_allocator import nfba_pkg::*; #(
  parameter int unsigned MAX_CLUSTERS = MAX_CLUSTERS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [TOT_W-1:0] cfg_wdata,
  nfba_req_if.sink         req,
  nfba_rsp_if.source       rsp
);

  localparam int unsigned ID_SPAN   = (MAX_CLUSTERS < ID_LIMIT) ? MAX_CLUSTERS : ID_LIMIT;
  localparam int unsigned MAP_DEPTH = (ID_SPAN + 7) / 8;
  localparam int unsigned ADDR_W    = $clog2(MAP_DEPTH);
  localparam logic [TOT_W-1:0]  SPAN_TOT  = TOT_W'(ID_SPAN);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAP_DEPTH - 1);

  state_t state, state_next;

  // Configuration and persistent state
  logic [TOT_W-1:0] total_clusters;
  logic [TOT_W-1:0] used_total;
  logic [ID_W-1:0]  next_cursor;
  logic [ADDR_W-1:0] clr_addr;

  // Per-request registers
  op_t               op_q;
  logic [ID_W-1:0]   id_q;
  logic [NB_W-1:0]   nbytes;
  logic [NB_W-1:0]   scanned;
  logic [ADDR_W-1:0] byte_idx;
  logic [ID_W-1:0]   res_id;
  status_t           res_status;
  logic [ADDR_W-1:0] res_addr;
  logic [BYTE_W-1:0] res_byte;

  // Output register
  logic             out_valid;
  logic [ID_W-1:0]  out_id;
  status_t          out_status;
  logic [TOT_W-1:0] out_free;

  // RAM ports
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [BYTE_W-1:0] ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [BYTE_W-1:0] ram_rdata;

  // Combinational helpers
  logic [TOT_W-1:0]  tot;
  logic [TOT_W-1:0]  tot_pad;
  logic [NB_W-1:0]   tot_nbytes;
  logic [ID_W-1:0]   cur_eff;
  logic [ADDR_W-1:0] start_addr;
  logic [ADDR_W-1:0] free_addr;
  logic              free_oor;
  logic [TOT_W-1:0]  base;
  logic [TOT_W-1:0]  rem;
  logic [BYTE_W-1:0] valid_mask;
  logic [BYTE_W-1:0] avail;
  logic              hit;
  logic [2:0]        pos;
  logic              scan_last;
  logic [NB_W-1:0]   byte_inc;
  logic [ADDR_W-1:0] byte_wrap;
  logic [BYTE_W-1:0] free_mark;
  logic              is_used;
  logic              fire;
  logic [TOT_W-1:0]  used_upd;
  logic [TOT_W-1:0]  free_cnt;
  logic [TOT_W-1:0]  cursor_inc;

  nfba_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MAP_DEPTH)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Effective total and request decode
  assign tot        = (total_clusters > SPAN_TOT) ? SPAN_TOT : total_clusters;
  assign tot_pad    = tot + TOT_W'(7);
  assign tot_nbytes = tot_pad[TOT_W-1:3];
  assign cur_eff    = ({1'b0, next_cursor} < tot) ? next_cursor : '0;
  assign start_addr = ADDR_W'(cur_eff >> 3);
  assign free_addr  = ADDR_W'(req.free_id >> 3);
  assign free_oor   = ({1'b0, req.free_id} >= tot);

  // Mask off clusters at or past the total in the current byte
  assign base       = TOT_W'({byte_idx, 3'b000});
  assign rem        = tot - base;
  assign valid_mask = (rem >= TOT_W'(BYTE_W)) ? '1 : ~(8'hFF >> rem[2:0]);
  assign avail      = ~ram_rdata & valid_mask;

  // Find the lowest free cluster (MSB first)
  always_comb begin
    hit = 1'b0;
    pos = '0;
    for (int i = BYTE_W - 1; i >= 0; i--) begin
      if (avail[i] && !hit) begin
        hit = 1'b1;
        pos = 3'(BYTE_W - 1 - i);
      end
    end
  end

  // Advance the scan with wrap at the last byte of the volume
  assign scan_last = (scanned == nbytes - 1'b1);
  assign byte_inc  = NB_W'(byte_idx) + 1'b1;
  assign byte_wrap = (byte_inc == nbytes) ? '0 : ADDR_W'(byte_inc);

  // Free path bit test
  assign free_mark = TOP_MARK >> id_q[2:0];
  assign is_used   = |(ram_rdata & free_mark);

  // Commit values
  assign fire = (state == S_RESULT) && (!out_valid || rsp.ready);

  always_comb begin
    used_upd = used_total;
    if (res_status == ST_DONE) begin
      if (op_q == OP_ALLOC) begin
        used_upd = used_total + 1'b1;
      end else begin
        used_upd = used_total - 1'b1;
      end
    end
  end

  assign free_cnt   = (used_upd >= tot) ? '0 : tot - used_upd;
  assign cursor_inc = TOT_W'(res_id) + 1'b1;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state, RAM control and request ready
  always_comb begin
    state_next = state;
    req.ready  = 1'b0;
    ram_raddr  = byte_idx;
    ram_we     = 1'b0;
    ram_waddr  = res_addr;
    ram_wdata  = res_byte;
    case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = '0;
        if (clr_addr == LAST_ADDR) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        req.ready = 1'b1;
        ram_raddr = (req.op == OP_ALLOC) ? start_addr : free_addr;
        if (req.valid) begin
          if (req.op == OP_ALLOC) begin
            state_next = (tot == '0) ? S_RESULT : S_SCAN;
          end else begin
            state_next = free_oor ? S_RESULT : S_CHECK;
          end
        end
      end
      S_SCAN: begin
        ram_raddr = byte_wrap;
        if (hit || scan_last) begin
          state_next = S_RESULT;
        end
      end
      S_CHECK: begin
        state_next = S_RESULT;
      end
      S_RESULT: begin
        // The write-back lands before the next request can read the map
        ram_we = fire && (res_status == ST_DONE);
        if (fire) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      total_clusters <= TOTAL_RESET;
    end else if (cfg_we) begin
      total_clusters <= cfg_wdata;
    end
  end

  // Clearing pass address
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (state == S_CLEAR) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  // Hold the request and build the result
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (req.valid) begin
          op_q       <= req.op;
          id_q       <= req.free_id;
          nbytes     <= tot_nbytes;
          scanned    <= '0;
          byte_idx   <= start_addr;
          res_id     <= '0;
          res_addr   <= free_addr;
          if (req.op == OP_ALLOC && tot == '0) begin
            res_status <= ST_FULL;
          end else if (req.op == OP_FREE && free_oor) begin
            res_status <= ST_RANGE;
          end else begin
            res_status <= ST_DONE;
          end
        end
      end
      S_SCAN: begin
        if (hit) begin
          res_id     <= ID_W'({byte_idx, pos});
          res_status <= ST_DONE;
          res_addr   <= byte_idx;
          res_byte   <= ram_rdata | (TOP_MARK >> pos);
        end else if (scan_last) begin
          res_status <= ST_FULL;
        end else begin
          byte_idx <= byte_wrap;
          scanned  <= scanned + 1'b1;
        end
      end
      S_CHECK: begin
        res_byte   <= ram_rdata & ~free_mark;
        res_status <= is_used ? ST_DONE : ST_WAS_FREE;
      end
      default: begin
      end
    endcase
  end

  // Commit count and cursor on transfer into the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      used_total  <= '0;
      next_cursor <= '0;
    end else if (fire) begin
      used_total <= used_upd;
      if (op_q == OP_ALLOC && res_status == ST_DONE) begin
        next_cursor <= (cursor_inc >= tot) ? '0 : ID_W'(cursor_inc);
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_id     <= res_id;
      out_status <= res_status;
      out_free   <= free_cnt;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.granted_id = out_id;
  assign rsp.status     = out_status;
  assign rsp.free_count = out_free;

`ifndef SYNTHESIS
  a_full_no_id: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status == ST_FULL |-> rsp.granted_id == '0)
    else $error("full response carries a nonzero id");

  a_one_request: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("second request taken while one is in work");

  a_free_bound: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> rsp.free_count <= SPAN_TOT)
    else $error("free count above cluster span");

  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used_total <= SPAN_TOT)
    else $error("used count above cluster span");

  a_no_write_in_read: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN || state == S_CHECK) |-> !ram_we)
    else $error("map written during read phase");
`endif

endmodule

@@ test/tb_next_fit_bitmap_allocator.sv @@
// ----------------------------------------------------------------------------
// tb_next_fit_bitmap_allocator
// Self-checking bench for the next-fit cluster allocator. A cycle-free model
// of the bitmap, cursor and used count predicts each response at request
// transfer time. Directed tests hit the volume-size extremes, full and
// empty volumes, ignored frees and a lowered total. A long output hold-off
// fills the block, and random phases mix allocations and frees over many
// volume sizes with random gaps on both channels.
// ----------------------------------------------------------------------------
module tb_next_fit_bitmap_allocator import nfba_pkg::*;;

  typedef struct packed {
    logic [ID_W-1:0]  granted_id;
    status_t          status;
    logic [TOT_W-1:0] free_count;
  } alloc_rsp_t;

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic [TOT_W-1:0] cfg_wdata;

  nfba_req_if req_ch ();
  nfba_rsp_if rsp_ch ();

  next_fit_bitmap_allocator DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  // Allocator state as the bench sees it
  bit          cluster_used [0:ID_LIMIT-1];
  int unsigned cursor_pos;
  int unsigned used_count;
  int unsigned volume_total;

  alloc_rsp_t  awaited_rsp [$];
  int unsigned mismatch_count;
  int unsigned hold_cycles;
  bit          gapless;

  // Clock
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Time limit
  initial begin
    #(20 * 5_000_000);
    $display("Mismatches found");
    $finish;
  end

  // Work out the response to one request and update the cluster state
  function automatic alloc_rsp_t predict_cluster_op(input op_t op,
                                                    input logic [ID_W-1:0] id);
    alloc_rsp_t  r;
    int unsigned tot;
    int unsigned span;
    int unsigned base;
    int unsigned cid;
    int unsigned n;
    bit          found;
    tot = (volume_total > ID_LIMIT) ? ID_LIMIT : volume_total;
    r.granted_id = '0;
    r.status     = ST_DONE;
    if (op == OP_ALLOC) begin
      // Scan whole bytes from the byte that holds the cursor, wrapping
      span  = ((tot + 7) / 8) * 8;
      base  = ((cursor_pos < tot) ? cursor_pos : 0) & ~32'd7;
      found = 1'b0;
      for (n = 0; n < span && !found; n++) begin
        cid = base + n;
        if (cid >= span) cid -= span;
        if (cid < tot && !cluster_used[cid]) begin
          cluster_used[cid] = 1'b1;
          if (used_count < 32'h1FFFF) used_count++;
          cursor_pos = (cid + 1 >= tot) ? 0 : cid + 1;
          r.granted_id = cid[ID_W-1:0];
          found = 1'b1;
        end
      end
      if (!found) r.status = ST_FULL;
    end else begin
      if (id >= tot) begin
        r.status = ST_RANGE;
      end else if (!cluster_used[id]) begin
        r.status = ST_WAS_FREE;
      end else begin
        cluster_used[id] = 1'b0;
        if (used_count > 0) used_count--;
      end
    end
    r.free_count = (used_count >= tot) ? '0 : TOT_W'(tot - used_count);
    return r;
  endfunction

  // Offer one request; leave valid high so a back-to-back request keeps it
  task automatic send_request(input op_t op, input logic [ID_W-1:0] id);
    int unsigned gap;
    gap = gapless ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      req_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid   = 1'b1;
    req_ch.op      = op;
    req_ch.free_id = id;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    awaited_rsp.push_back(predict_cluster_op(op, id));
    @(negedge clk);
  endtask

  // Drop valid and wait for every response to come back
  task automatic drain();
    req_ch.valid = 1'b0;
    while (awaited_rsp.size() > 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // Write the volume size; only called while the block is idle
  task automatic set_total(input int unsigned value);
    cfg_we    = 1'b1;
    cfg_wdata = value[TOT_W-1:0];
    @(negedge clk);
    cfg_we       = 1'b0;
    volume_total = value;
  endtask

  function automatic logic [ID_W-1:0] pick_free_id(input int unsigned tot);
    int unsigned r;
    int unsigned c;
    r = $urandom_range(0, 99);
    if (r < 10 || tot == 0) return ID_W'($urandom_range(0, 65535));
    if (r < 20) return ID_W'($urandom_range(0, tot - 1));
    // Prefer a cluster that is in use
    c = $urandom_range(0, tot - 1);
    repeat (8) begin
      if (cluster_used[c]) return c[ID_W-1:0];
      c = $urandom_range(0, tot - 1);
    end
    return c[ID_W-1:0];
  endfunction

  function automatic logic [ID_W-1:0] noise_id();
    return ID_W'($urandom_range(0, 65535));
  endfunction

  // Response side: per-item stall, optional long hold-off
  initial begin
    int unsigned stall;
    rsp_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_cycles > 0) begin
        rsp_ch.ready = 1'b0;
        repeat (hold_cycles) @(negedge clk);
        hold_cycles = 0;
      end
      stall = gapless ? 0 : $urandom_range(0, 12);
      if (stall > 0) begin
        rsp_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp_ch.ready = 1'b1;
      do @(posedge clk); while (rsp_ch.valid !== 1'b1 && hold_cycles == 0);
      @(negedge clk);
    end
  end

  // Compare each response transfer with the oldest prediction
  always @(posedge clk) begin
    alloc_rsp_t want;
    if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      if (awaited_rsp.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: unexpected response id=%0d status=%0d free=%0d", $realtime,
                   rsp_ch.granted_id, rsp_ch.status, rsp_ch.free_count);
      end else begin
        want = awaited_rsp.pop_front();
        if (rsp_ch.granted_id !== want.granted_id || rsp_ch.status !== want.status ||
            rsp_ch.free_count !== want.free_count) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: expected id=%0d status=%0d free=%0d, got id=%0d status=%0d free=%0d",
                     $realtime, want.granted_id, want.status, want.free_count,
                     rsp_ch.granted_id, rsp_ch.status, rsp_ch.free_count);
        end
      end
    end
  end

  // Reset-value volume: first grants, ignored free of a clear cluster
  task automatic test_default_total();
    send_request(OP_ALLOC, noise_id());
    send_request(OP_ALLOC, noise_id());
    send_request(OP_FREE, 16'hFFFF);
    send_request(OP_FREE, 16'd0);
    send_request(OP_FREE, 16'd1);
    drain();
  endtask

  // One-cluster volume: grant, full, out of range, double free
  task automatic test_single_cluster();
    set_total(1);
    send_request(OP_ALLOC, noise_id());
    send_request(OP_ALLOC, noise_id());
    send_request(OP_FREE, 16'hFFFF);
    send_request(OP_FREE, 16'd0);
    send_request(OP_FREE, 16'd0);
    drain();
  endtask

  // Empty volume: nothing can be granted or freed
  task automatic test_empty_volume();
    set_total(0);
    send_request(OP_ALLOC, noise_id());
    send_request(OP_FREE, 16'd0);
    drain();
  endtask

  // Volume ending inside a byte, then lowered under the used count
  task automatic test_partial_byte();
    set_total(3);
    repeat (4) send_request(OP_ALLOC, noise_id());
    drain();
    set_total(2);
    send_request(OP_ALLOC, noise_id());
    send_request(OP_FREE, 16'd2);
    drain();
    set_total(3);
    send_request(OP_FREE, 16'd2);
    drain();
  endtask

  // Hold the response channel while requests keep coming
  task automatic test_backpressure();
    int unsigned k;
    set_total(ID_LIMIT);
    gapless     = 1'b1;
    hold_cycles = 300;
    for (k = 0; k < 24; k++) begin
      if (k % 3 == 2) send_request(OP_FREE, pick_free_id(volume_total));
      else send_request(OP_ALLOC, noise_id());
    end
    drain();
    gapless = 1'b0;
  endtask

  // Random phases, each with its own volume size and operation mix
  task automatic test_random_mix();
    int unsigned done_items;
    int unsigned phase_len;
    int unsigned alloc_pct;
    int unsigned pick;
    int unsigned tot;
    done_items = 0;
    while (done_items < 1350) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) tot = 0;
      else if (pick < 13) tot = ID_LIMIT;
      else if (pick < 23) tot = $urandom_range(1, 65535);
      else if (pick < 60) tot = $urandom_range(1, 24);
      else tot = $urandom_range(1, 320);
      set_total(tot);
      gapless   = ($urandom_range(0, 3) == 0);
      phase_len = (pick >= 13 && pick < 23) ? $urandom_range(4, 20) : $urandom_range(20, 70);
      alloc_pct = (pick >= 13 && pick < 23) ? $urandom_range(20, 50) : $urandom_range(25, 85);
      repeat (phase_len) begin
        if ($urandom_range(0, 99) < alloc_pct) send_request(OP_ALLOC, noise_id());
        else send_request(OP_FREE, pick_free_id(tot));
        done_items++;
      end
      drain();
    end
    gapless = 1'b0;
  endtask

  // Main sequence
  initial begin
    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    req_ch.valid   = 1'b0;
    req_ch.op      = OP_ALLOC;
    req_ch.free_id = '0;
    cursor_pos     = 0;
    used_count     = 0;
    volume_total   = TOTAL_RESET;
    mismatch_count = 0;
    hold_cycles    = 0;
    gapless        = 1'b0;
    repeat (5) @(negedge clk);
    rst = 1'b0;

    test_default_total();
    test_single_cluster();
    test_empty_volume();
    test_partial_byte();
    test_backpressure();
    test_random_mix();

    repeat (20) @(negedge clk);
    if (mismatch_count == 0 && awaited_rsp.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
